// ===== hdl/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared constants, widths and the hue sector type.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

   // default full scale of the incoming hue, saturation and value
   localparam int SCALE_DEFAULT = 1000;

   // raw field width of a request
   localparam int RAW_W = 32;

   // output ranges
   localparam int HUE_RANGE  = 360;
   localparam int FULL_LEVEL = 255;
   localparam int BASE_SHIFT = 8;

   // hue sectors
   localparam int SECTOR_WIDTH = 60;
   localparam int SECTORS      = HUE_RANGE / SECTOR_WIDTH;

   // derived widths
   localparam int HUE_W    = $clog2(HUE_RANGE);
   localparam int LEVEL_W  = $clog2(FULL_LEVEL + 1);
   localparam int OFFSET_W = $clog2(SECTOR_WIDTH + 1);
   localparam int SECT_W   = $clog2(SECTORS);
   localparam int PROD_W   = LEVEL_W + OFFSET_W;

   // exact division by the sector width for products below 2**PROD_W
   localparam int DIV60_SHIFT = 20;
   localparam int DIV60_MULT  = ((2 ** DIV60_SHIFT) + SECTOR_WIDTH - 1) / SECTOR_WIDTH;
   localparam int DIV60_W     = $clog2(DIV60_MULT + 1);

   typedef enum logic [SECT_W-1:0] {
      SECTOR_RED_YELLOW,
      SECTOR_YELLOW_GREEN,
      SECTOR_GREEN_CYAN,
      SECTOR_CYAN_BLUE,
      SECTOR_BLUE_MAGENTA,
      SECTOR_MAGENTA_RED
   } sector_type;

endpackage

// ===== hdl/hsv2rgb_if.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter channels
// Valid/ready request and response channels with their payload.
// ----------------------------------------------------------------------------
interface hsv2rgb_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [hsv2rgb_pkg::RAW_W-1:0] hue_in;
   logic signed [hsv2rgb_pkg::RAW_W-1:0] saturation_in;
   logic signed [hsv2rgb_pkg::RAW_W-1:0] value_in;

   modport source (output valid, output hue_in, output saturation_in, output value_in,
                   input ready);
   modport sink   (input valid, input hue_in, input saturation_in, input value_in,
                   output ready);
endinterface

interface hsv2rgb_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [hsv2rgb_pkg::LEVEL_W-1:0]    red;
   logic [hsv2rgb_pkg::LEVEL_W-1:0]    green;
   logic [hsv2rgb_pkg::LEVEL_W-1:0]    blue;
   logic                               chromatic;

   modport source (output valid, output red, output green, output blue, output chromatic,
                   input ready);
   modport sink   (input valid, input red, input green, input blue, input chromatic,
                   output ready);
endinterface

// ===== hdl/hsv2rgb_lane.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB rescale lane
// Clamps one raw field into 0..SCALE-1 and computes (x * FACTOR) / SCALE
// over three stages: clamp and scale, reciprocal multiply, correction.
// ----------------------------------------------------------------------------
module hsv2rgb_lane #(
   parameter int SCALE  = hsv2rgb_pkg::SCALE_DEFAULT,
   parameter int FACTOR = hsv2rgb_pkg::FULL_LEVEL,
   parameter int QW     = hsv2rgb_pkg::LEVEL_W
) (
   input  logic                                 clock,
   input  logic [2:0]                           enable,
   input  logic signed [hsv2rgb_pkg::RAW_W-1:0] raw_in,
   output logic [QW-1:0]                        quot
);
   import hsv2rgb_pkg::*;

   localparam int CW    = $clog2(SCALE);
   localparam int XW    = $clog2((SCALE - 1) * FACTOR + 1);
   localparam int K     = XW;
   localparam int RECIP = (2 ** K) / SCALE;
   localparam int RW    = K - CW + 2;
   localparam int PW    = XW + RW;

   logic [CW-1:0] clamped;
   logic [XW-1:0] scaled_in, scaled_ff;
   logic [PW-1:0] recip_prod;
   logic [QW-1:0] est_in, est_ff;
   logic [XW-1:0] est_x_ff;
   logic [XW-1:0] remainder;
   logic [QW-1:0] quot_in, quot_ff;

   // clamp into 0..SCALE-1 and apply the range factor
   always_comb begin
      if (raw_in[RAW_W-1]) begin
         clamped = '0;
      end else if (raw_in >= RAW_W'(SCALE)) begin
         clamped = CW'(SCALE - 1);
      end else begin
         clamped = raw_in[CW-1:0];
      end
      scaled_in = XW'(clamped) * XW'(FACTOR);
   end

   // quotient estimate, low by at most one
   always_comb begin
      recip_prod = PW'(scaled_ff) * PW'(RECIP);
      est_in     = recip_prod[K +: QW];
   end

   // one compare and subtract fixes the estimate
   always_comb begin
      remainder = est_x_ff - XW'(XW'(est_ff) * XW'(SCALE));
      quot_in   = (remainder >= XW'(SCALE)) ? est_ff + QW'(1) : est_ff;
   end

   always_ff @(posedge clock) begin
      if (enable[0]) begin
         scaled_ff <= scaled_in;
      end
      if (enable[1]) begin
         est_ff   <= est_in;
         est_x_ff <= scaled_ff;
      end
      if (enable[2]) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

// ===== hdl/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Throughput: one request per cycle while responses are taken; a stalled
// response holds only the stages that carry data, so bubbles are squeezed
// out behind it.
// Reset is synchronous and clears the stage valid bits; data needs no reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter #(
   parameter int SCALE = hsv2rgb_pkg::SCALE_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   hsv2rgb_req_if.sink   req_channel,
   hsv2rgb_rsp_if.source rsp_channel
);
   import hsv2rgb_pkg::*;

   localparam int STAGES = 6;

   logic [STAGES-1:0] valid_ff, valid_in, valid_prev;
   logic [STAGES:0]   stage_en;

   logic [HUE_W-1:0]   hue_q;
   logic [LEVEL_W-1:0] sat_q, val_q;

   logic [2*LEVEL_W-1:0] base_prod;
   logic [SECT_W-1:0]    sector_idx;
   logic [OFFSET_W-1:0]  offset;

   logic [LEVEL_W-1:0]  base3_ff, val3_ff;
   sector_type          sector3_ff;
   logic [OFFSET_W-1:0] off3_ff;
   logic                gray3_ff;

   logic [OFFSET_W-1:0] ramp_num;
   logic [PROD_W-1:0]   ramp_prod_in, ramp_prod4_ff;
   logic [LEVEL_W-1:0]  base4_ff, val4_ff;
   sector_type          sector4_ff;
   logic                gray4_ff;

   logic [PROD_W+DIV60_W-1:0] div_prod;
   logic [LEVEL_W-1:0]        ramp;
   logic [LEVEL_W-1:0]        red_in, green_in, blue_in;
   logic [LEVEL_W-1:0]        red_ff, green_ff, blue_ff;
   logic                      chromatic_ff;

   // stage enables: a stage moves when empty or when the next one moves
   always_comb begin
      stage_en[STAGES] = rsp_channel.ready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i + 1];
      end
   end

   // valid bits travel with the data
   always_comb begin
      valid_prev = {valid_ff[STAGES-2:0], req_channel.valid};
      for (int i = 0; i < STAGES; i++) begin
         valid_in[i] = stage_en[i] ? valid_prev[i] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_channel.ready = stage_en[0];

   // stages 1 to 3: clamp and rescale each field
   hsv2rgb_lane #(.SCALE(SCALE), .FACTOR(HUE_RANGE), .QW(HUE_W)) u_hue_lane (
      .clock  (clock),
      .enable (stage_en[2:0]),
      .raw_in (req_channel.hue_in),
      .quot   (hue_q)
   );

   hsv2rgb_lane #(.SCALE(SCALE), .FACTOR(FULL_LEVEL), .QW(LEVEL_W)) u_sat_lane (
      .clock  (clock),
      .enable (stage_en[2:0]),
      .raw_in (req_channel.saturation_in),
      .quot   (sat_q)
   );

   hsv2rgb_lane #(.SCALE(SCALE), .FACTOR(FULL_LEVEL), .QW(LEVEL_W)) u_val_lane (
      .clock  (clock),
      .enable (stage_en[2:0]),
      .raw_in (req_channel.value_in),
      .quot   (val_q)
   );

   // stage 4: base level, sector and offset within the sector
   always_comb begin
      base_prod  = (2*LEVEL_W)'(LEVEL_W'(FULL_LEVEL) - sat_q) * (2*LEVEL_W)'(val_q);
      sector_idx = '0;
      for (int k = 1; k < SECTORS; k++) begin
         if (hue_q >= HUE_W'(k * SECTOR_WIDTH)) begin
            sector_idx = SECT_W'(k);
         end
      end
      offset = OFFSET_W'(hue_q - HUE_W'(HUE_W'(sector_idx) * HUE_W'(SECTOR_WIDTH)));
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         base3_ff   <= base_prod[BASE_SHIFT +: LEVEL_W];
         val3_ff    <= val_q;
         sector3_ff <= sector_type'(sector_idx);
         off3_ff    <= offset;
         gray3_ff   <= (sat_q == '0);
      end
   end

   // stage 5: ramp product, rising in even sectors and falling in odd ones
   always_comb begin
      case (sector3_ff)
         SECTOR_RED_YELLOW,
         SECTOR_GREEN_CYAN,
         SECTOR_BLUE_MAGENTA: begin
            ramp_num = off3_ff;
         end
         default: begin
            ramp_num = OFFSET_W'(SECTOR_WIDTH) - off3_ff;
         end
      endcase
      ramp_prod_in = PROD_W'(val3_ff - base3_ff) * PROD_W'(ramp_num);
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         ramp_prod4_ff <= ramp_prod_in;
         base4_ff      <= base3_ff;
         val4_ff       <= val3_ff;
         sector4_ff    <= sector3_ff;
         gray4_ff      <= gray3_ff;
      end
   end

   // stage 6: divide by the sector width and route the channels
   always_comb begin
      div_prod = (PROD_W+DIV60_W)'(ramp_prod4_ff) * (PROD_W+DIV60_W)'(DIV60_MULT);
      ramp     = div_prod[DIV60_SHIFT +: LEVEL_W] + base4_ff;
      if (gray4_ff) begin
         red_in   = val4_ff;
         green_in = val4_ff;
         blue_in  = val4_ff;
      end else begin
         case (sector4_ff)
            SECTOR_RED_YELLOW: begin
               red_in = val4_ff;  green_in = ramp;     blue_in = base4_ff;
            end
            SECTOR_YELLOW_GREEN: begin
               red_in = ramp;     green_in = val4_ff;  blue_in = base4_ff;
            end
            SECTOR_GREEN_CYAN: begin
               red_in = base4_ff; green_in = val4_ff;  blue_in = ramp;
            end
            SECTOR_CYAN_BLUE: begin
               red_in = base4_ff; green_in = ramp;     blue_in = val4_ff;
            end
            SECTOR_BLUE_MAGENTA: begin
               red_in = ramp;     green_in = base4_ff; blue_in = val4_ff;
            end
            default: begin
               red_in = val4_ff;  green_in = base4_ff; blue_in = ramp;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
         chromatic_ff <= !gray4_ff;
      end
   end

   assign rsp_channel.valid     = valid_ff[STAGES-1];
   assign rsp_channel.red       = red_ff;
   assign rsp_channel.green     = green_ff;
   assign rsp_channel.blue      = blue_ff;
   assign rsp_channel.chromatic = chromatic_ff;

endmodule

// ===== hdl/hsv2rgb_checker.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter checker
// Port-level properties of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsv2rgb_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [hsv2rgb_pkg::LEVEL_W-1:0]    rsp_red,
   input logic [hsv2rgb_pkg::LEVEL_W-1:0]    rsp_green,
   input logic [hsv2rgb_pkg::LEVEL_W-1:0]    rsp_blue,
   input logic                               rsp_chromatic
);
   import hsv2rgb_pkg::*;

   // a waiting response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green)
                                  && $stable(rsp_blue) && $stable(rsp_chromatic))
      else $error("stalled response changed");

   // gray responses carry equal channels
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_chromatic |-> rsp_red == rsp_green && rsp_green == rsp_blue)
      else $error("gray response with unequal channels");

   // no channel reaches full level
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_red != LEVEL_W'(FULL_LEVEL) && rsp_green != LEVEL_W'(FULL_LEVEL)
                    && rsp_blue != LEVEL_W'(FULL_LEVEL))
      else $error("channel at full level");

   // reset empties the pipeline
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a draining output never blocks requests
   assert property (@(posedge clock) disable iff (reset) rsp_ready |-> req_ready)
      else $error("request blocked while response side is ready");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_channel.ready),
   .rsp_valid     (rsp_channel.valid),
   .rsp_ready     (rsp_channel.ready),
   .rsp_red       (rsp_channel.red),
   .rsp_green     (rsp_channel.green),
   .rsp_blue      (rsp_channel.blue),
   .rsp_chromatic (rsp_channel.chromatic)
);
